// ===== hdl/mepq_pkg.sv =====
// Shared types and constants for the monotone event priority queue.
package mepq_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int INDEX_BITS_DEF = 16;
    localparam int KEY_W          = 64;
    localparam int PORT_IDX_W     = 16;
    localparam int OCC_W          = 11;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_LATE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== hdl/monotone_event_priority_queue.sv =====
// Top level of the monotone event priority queue: control, status and the cell chain.
//
// Input channel (in_valid/in_stall): one transaction is a push (mode 0) of
// event_key/entry_index or a pop (mode 1). Output channel (out_valid/out_stall):
// exactly one result transaction per input transaction, in order, carrying
// out_key/out_index of the popped event (zero otherwise), status and occupancy.
// Events live in a chain of CAPACITY cells kept sorted by key then index; a
// push inserts in place by a parallel compare in every cell, a pop shifts the
// chain toward the head. Each transaction's result is in the output register
// the cycle after acceptance, and a new input can be accepted every cycle,
// limited only by the one-entry output register. While a result waits under
// out_stall, in_stall is raised and the queue holds.
// Reset (rst_n, asynchronous, active low) empties every cell, clears the
// occupancy and the last popped key, and drops any pending result; the
// queue is ready in the first cycle after reset.
module monotone_event_priority_queue
    import mepq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [KEY_W-1:0]      event_key,
    input  logic [PORT_IDX_W-1:0] entry_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_W-1:0]      out_key,
    output logic [PORT_IDX_W-1:0] out_index,
    output logic [1:0]            status,
    output logic [OCC_W-1:0]      occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  cv    [CAPACITY];
    logic [KEY_W-1:0]      ck    [CAPACITY];
    logic [INDEX_BITS-1:0] ci    [CAPACITY];
    logic                  clt   [CAPACITY];

    logic [INDEX_BITS-1:0] idx_in;
    logic                  accept;
    logic                  do_push;
    logic                  do_pop;
    cell_ctrl_t            ctrl;
    status_t               st;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [KEY_W-1:0]      last_key_reg;
    logic                  out_valid_reg;
    logic [KEY_W-1:0]      out_key_reg;
    logic [PORT_IDX_W-1:0] out_index_reg;
    logic [PORT_IDX_W-1:0] head_idx_port;
    logic [1:0]            status_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        idx_in = '0;
        for (int b = 0; b < INDEX_BITS && b < PORT_IDX_W; b++)
        begin
            idx_in[b] = entry_index[b];
        end
    end

    always_comb
    begin
        head_idx_port = '0;
        for (int b = 0; b < INDEX_BITS && b < PORT_IDX_W; b++)
        begin
            head_idx_port[b] = ci[0][b];
        end
    end

    always_comb
    begin
        st      = ST_OK;
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (!mode)
        begin
            if (event_key < last_key_reg)
            begin
                st = ST_LATE;
            end
            else if (count_reg == CNT_W'(CAPACITY))
            begin
                st = ST_FULL;
            end
            else
            begin
                do_push = accept;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                st = ST_EMPTY;
            end
            else
            begin
                do_pop = accept;
            end
        end
    end

    assign ctrl.push = do_push;
    assign ctrl.pop  = do_pop;

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        occ_next = '0;
        for (int b = 0; b < OCC_W && b < CNT_W; b++)
        begin
            occ_next[b] = count_next[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_key_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_pop)
            begin
                last_key_reg <= ck[0];
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_key_reg   <= do_pop ? ck[0] : '0;
            out_index_reg <= do_pop ? head_idx_port : '0;
            status_reg    <= st;
            occ_reg       <= occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_index = out_index_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  lv;
        logic [KEY_W-1:0]      lk;
        logic [INDEX_BITS-1:0] li;
        logic                  llt;
        logic                  rv;
        logic [KEY_W-1:0]      rk;
        logic [INDEX_BITS-1:0] ri;

        if (i == 0)
        begin : g_head
            assign lv  = 1'b0;
            assign lk  = '0;
            assign li  = '0;
            assign llt = 1'b0;
        end
        else
        begin : g_mid
            assign lv  = cv[i-1];
            assign lk  = ck[i-1];
            assign li  = ci[i-1];
            assign llt = clt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rk = '0;
            assign ri = '0;
        end
        else
        begin : g_body
            assign rv = cv[i+1];
            assign rk = ck[i+1];
            assign ri = ci[i+1];
        end

        mepq_cell #(
            .INDEX_BITS(INDEX_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_key    (event_key),
            .new_idx    (idx_in),
            .left_valid (lv),
            .left_key   (lk),
            .left_idx   (li),
            .left_lt    (llt),
            .right_valid(rv),
            .right_key  (rk),
            .right_idx  (ri),
            .cell_valid (cv[i]),
            .cell_key   (ck[i]),
            .cell_idx   (ci[i]),
            .cell_lt    (clt[i])
        );
    end

endmodule

// ===== hdl/mepq_cell.sv =====
// One cell of the sorted chain: holds one event, shifts right on insert, left on pop.
module mepq_cell
    import mepq_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [KEY_W-1:0]      new_key,
    input  logic [INDEX_BITS-1:0] new_idx,
    input  logic                  left_valid,
    input  logic [KEY_W-1:0]      left_key,
    input  logic [INDEX_BITS-1:0] left_idx,
    input  logic                  left_lt,
    input  logic                  right_valid,
    input  logic [KEY_W-1:0]      right_key,
    input  logic [INDEX_BITS-1:0] right_idx,
    output logic                  cell_valid,
    output logic [KEY_W-1:0]      cell_key,
    output logic [INDEX_BITS-1:0] cell_idx,
    output logic                  cell_lt
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] idx_next;

    // new event sorts before this cell's event (empty cell counts as infinite)
    assign cell_lt = !valid_reg || (new_key < key_reg) ||
                     ((new_key == key_reg) && (new_idx < idx_reg));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        if (ctrl.pop)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            idx_next   = right_idx;
        end
        else if (ctrl.push)
        begin
            if (left_lt)
            begin
                valid_next = left_valid;
                key_next   = left_key;
                idx_next   = left_idx;
            end
            else if (cell_lt)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                idx_next   = new_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    assign cell_valid = valid_reg;
    assign cell_key   = key_reg;
    assign cell_idx   = idx_reg;

endmodule
